[src/rpcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpcc_pkg;

  // Fixed field widths
  localparam int unsigned RELAY_W = 2;
  localparam int unsigned RELAY_N = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned AUTO_W = 27;
  localparam int unsigned SINCE_W = 10;
  localparam int unsigned CYCLE_W = 17;
  localparam int unsigned LIMIT_W = 24;

  localparam int unsigned RECENT_MS = 800;
  localparam int unsigned MS_PER_SEC = 1000;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CYCLE_R0 = 3'd0;
  localparam logic [2:0] REG_LIMIT_R0 = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PRESS = 2'd1,
    OP_CLR   = 2'd2,
    OP_NONE  = 2'd3
  } op_e_t;

  typedef enum logic [2:0] {
    M_NONE,
    M_UPD,
    M_SCAN,
    M_PRESS,
    M_CLR,
    M_RPT
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_SCAN,
    S_PRESS,
    S_CLR,
    S_RPT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cyc;
    logic [COUNT_W-1:0] press;
    logic               active;
    logic [PULSE_W-1:0] pulse;
    logic [AUTO_W-1:0]  autoel;
    logic [SINCE_W-1:0] since;
  } relay_state_t;

  typedef struct packed {
    logic drive;
    logic full;
    logic autof;
    logic recent;
  } relay_flags_t;

  typedef struct packed {
    mode_t              mode;
    logic [RELAY_W-1:0] idx;
    logic [RELAY_W-1:0] rel;
    logic               rel_ok;
    logic               start;
    logic               load_out;
  } seq_ctrl_t;

endpackage

`default_nettype wire

[src/rpcc_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpcc_unit #(
  parameter int unsigned PULSE_TICKS = 500,
  parameter int unsigned COUNT_EVERY_PRESS = 0
) (
  input  rpcc_pkg::mode_t                       mode,
  input  rpcc_pkg::relay_state_t                cur,
  input  logic [rpcc_pkg::LIMIT_W-1:0]          limit,
  input  logic [rpcc_pkg::AUTO_W-1:0]           cycle_ms,
  input  logic                                  cycle_nz,
  output rpcc_pkg::relay_state_t                nxt,
  output logic                                  refused,
  output rpcc_pkg::relay_flags_t                flags
);

  logic                             limited;
  logic                             full;
  logic                             due;
  logic                             fire;
  logic [rpcc_pkg::COUNT_W-1:0]     press_inc;
  logic [rpcc_pkg::PULSE_W-1:0]     pulse_inc;

  // Limit and due tests on the visited relay
  assign limited   = (limit > rpcc_pkg::LIMIT_W'(1)) &&
                     (cur.cyc >= rpcc_pkg::COUNT_W'(limit));
  assign full      = (limit == rpcc_pkg::LIMIT_W'(1)) || limited;
  assign due       = cycle_nz && !full && (cur.autoel >= cycle_ms);
  assign press_inc = cur.press + rpcc_pkg::COUNT_W'(1);
  assign pulse_inc = (cur.pulse != '1) ? cur.pulse + rpcc_pkg::PULSE_W'(1) : cur.pulse;
  assign fire      = ((mode == rpcc_pkg::M_SCAN) && due) ||
                     ((mode == rpcc_pkg::M_PRESS) && !limited);

  // Status bits of the visited relay
  assign flags.drive  = cur.active;
  assign flags.full   = full;
  assign flags.autof  = cycle_nz && !full;
  assign flags.recent = (cur.since <= rpcc_pkg::SINCE_W'(rpcc_pkg::RECENT_MS));

  // Next state of the visited relay
  always_comb begin
    nxt     = cur;
    refused = 1'b0;
    unique case (mode)
      rpcc_pkg::M_UPD: begin
        nxt.pulse = pulse_inc;
        if (cur.autoel != '1) nxt.autoel = cur.autoel + rpcc_pkg::AUTO_W'(1);
        if (cur.since != '1) nxt.since = cur.since + rpcc_pkg::SINCE_W'(1);
        if (cur.active && (pulse_inc >= rpcc_pkg::PULSE_W'(PULSE_TICKS))) nxt.active = 1'b0;
      end
      rpcc_pkg::M_SCAN: begin
        if (due) nxt.autoel = '0;
      end
      rpcc_pkg::M_PRESS: begin
        nxt.autoel = '0;
        refused    = limited;
      end
      rpcc_pkg::M_CLR: begin
        nxt.cyc   = '0;
        nxt.press = '0;
      end
      rpcc_pkg::M_NONE, rpcc_pkg::M_RPT: begin
        nxt = cur;
      end
    endcase
    // Drive the coil and count the press
    if (fire) begin
      nxt.active = 1'b1;
      nxt.pulse  = '0;
      nxt.press  = press_inc;
      nxt.since  = '0;
      if ((COUNT_EVERY_PRESS != 0) || press_inc[0]) begin
        nxt.cyc = cur.cyc + rpcc_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/rpcc_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpcc_seq #(
  parameter int unsigned RELAYS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [1:0]                   in_op,
  input  logic [rpcc_pkg::RELAY_W-1:0] in_rel,
  output logic                         in_ready,
  input  logic                         busy,
  input  logic                         out_free,
  output rpcc_pkg::seq_ctrl_t          ctrl
);

  localparam logic [rpcc_pkg::RELAY_W-1:0] LAST = rpcc_pkg::RELAY_W'(RELAYS - 1);

  rpcc_pkg::state_t           state, state_next;
  logic [rpcc_pkg::RELAY_W-1:0] idx, idx_next;
  logic [rpcc_pkg::RELAY_W-1:0] rel;
  logic                         rel_ok;
  logic                         in_ok;
  logic                         accept;
  rpcc_pkg::op_e_t              op_in;

  assign op_in    = rpcc_pkg::op_e_t'(in_op);
  assign in_ok    = ({1'b0, in_rel} < 3'(RELAYS));
  assign in_ready = (state == rpcc_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // State, index and latched relay
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rpcc_pkg::S_IDLE;
      idx    <= '0;
      rel    <= '0;
      rel_ok <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept) begin
        rel    <= in_rel;
        rel_ok <= in_ok;
      end
    end
  end

  // Advance through the relays one per cycle
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    ctrl.mode     = rpcc_pkg::M_NONE;
    ctrl.idx      = idx;
    ctrl.rel      = rel;
    ctrl.rel_ok   = rel_ok;
    ctrl.start    = accept;
    ctrl.load_out = 1'b0;
    unique case (state)
      rpcc_pkg::S_IDLE: begin
        if (in_valid) begin
          idx_next = '0;
          unique case (op_in)
            rpcc_pkg::OP_TICK:  state_next = rpcc_pkg::S_UPD;
            rpcc_pkg::OP_PRESS: begin
              state_next = in_ok ? rpcc_pkg::S_PRESS : rpcc_pkg::S_RPT;
              if (in_ok) idx_next = in_rel;
            end
            rpcc_pkg::OP_CLR: begin
              state_next = in_ok ? rpcc_pkg::S_CLR : rpcc_pkg::S_RPT;
              if (in_ok) idx_next = in_rel;
            end
            rpcc_pkg::OP_NONE:  state_next = rpcc_pkg::S_RPT;
          endcase
        end
      end
      rpcc_pkg::S_UPD: begin
        ctrl.mode = rpcc_pkg::M_UPD;
        if (idx == LAST) begin
          state_next = rpcc_pkg::S_CHK;
          idx_next   = '0;
        end else begin
          idx_next = idx + rpcc_pkg::RELAY_W'(1);
        end
      end
      rpcc_pkg::S_CHK: begin
        state_next = busy ? rpcc_pkg::S_RPT : rpcc_pkg::S_SCAN;
        idx_next   = '0;
      end
      rpcc_pkg::S_SCAN: begin
        ctrl.mode = rpcc_pkg::M_SCAN;
        if (idx == LAST) begin
          state_next = rpcc_pkg::S_RPT;
          idx_next   = '0;
        end else begin
          idx_next = idx + rpcc_pkg::RELAY_W'(1);
        end
      end
      rpcc_pkg::S_PRESS: begin
        ctrl.mode  = rpcc_pkg::M_PRESS;
        state_next = rpcc_pkg::S_RPT;
        idx_next   = '0;
      end
      rpcc_pkg::S_CLR: begin
        ctrl.mode  = rpcc_pkg::M_CLR;
        state_next = rpcc_pkg::S_RPT;
        idx_next   = '0;
      end
      rpcc_pkg::S_RPT: begin
        ctrl.mode = rpcc_pkg::M_RPT;
        if (idx == LAST) begin
          state_next = rpcc_pkg::S_DONE;
          idx_next   = '0;
        end else begin
          idx_next = idx + rpcc_pkg::RELAY_W'(1);
        end
      end
      rpcc_pkg::S_DONE: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = rpcc_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[src/relay_pulse_cycle_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Relay pulser with cycle counting for up to four relays. Each input beat is
// a 1 ms tick, a manual press or a count reset (kind in s_tuser, relay in
// s_tdata); each yields one result beat with the coil drive bits, the count
// of the addressed relay and per-relay full, auto and recent flags. A single
// relay update unit visits one relay per cycle under a small sequencer: a tick
// runs update, scan (skipped while a pulse runs) and report passes; a press or
// reset visits its relay, then reports; an unused code or unfitted relay only
// reports. The input is not ready while an item is at work; a finished result
// waits in the output register while the next item is taken. The user must
// write configuration over the APB port only while idle; the block does not
// enforce it. Writing either register of a relay restarts its auto-press timer.

module relay_pulse_cycle_counter_core #(
  parameter int unsigned RELAYS = 4,
  parameter int unsigned PULSE_TICKS = 500,
  parameter int unsigned COUNT_EVERY_PRESS = 0
) (
  input  logic        clk,
  input  logic        rst,
  // Input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] relay, [7:2] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  // Result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [3:0] relay_drive, [35:4] cycle_count,
                                 // [39:36] full_flags, [43:40] auto_flags,
                                 // [47:44] recent_flags, [48] refused, [55:49] zero
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = (RELAYS > 2) ? 2 : 1;

  rpcc_pkg::seq_ctrl_t    ctrl;
  rpcc_pkg::relay_state_t st [RELAYS];
  rpcc_pkg::relay_state_t nxt;
  rpcc_pkg::relay_flags_t flags;

  logic [rpcc_pkg::CYCLE_W-1:0] cycle_sec [RELAYS];
  logic [rpcc_pkg::AUTO_W-1:0]  cycle_ms  [RELAYS];
  logic [rpcc_pkg::LIMIT_W-1:0] limit     [RELAYS];

  logic [IDX_W-1:0]   ridx;
  logic [IDX_W-1:0]   cidx;
  logic [2:0]         creg;
  logic               cfg_wr;
  logic               cfg_ok;
  logic               writes_back;
  logic               busy;
  logic               unit_refused;
  logic [RELAYS-1:0]  active_vec;

  logic [rpcc_pkg::RELAY_N-1:0] drive_acc, full_acc, auto_acc, recent_acc;
  logic [rpcc_pkg::COUNT_W-1:0] count_acc;
  logic                         refused_acc;

  logic [rpcc_pkg::RELAY_N-1:0] relay_drive, full_flags, auto_flags, recent_flags;
  logic [rpcc_pkg::COUNT_W-1:0] cycle_count;
  logic                         refused;

  assign ridx   = ctrl.idx[IDX_W-1:0];
  assign creg   = paddr[4:2];
  assign cidx   = paddr[IDX_W+1:2];
  assign cfg_ok = ({1'b0, paddr[3:2]} < 3'(RELAYS));
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign writes_back = (ctrl.mode == rpcc_pkg::M_UPD) || (ctrl.mode == rpcc_pkg::M_SCAN) ||
                       (ctrl.mode == rpcc_pkg::M_PRESS) || (ctrl.mode == rpcc_pkg::M_CLR);

  // Busy test after the update pass
  always_comb begin
    for (int i = 0; i < RELAYS; i++) active_vec[i] = st[i].active;
  end
  assign busy = |active_vec;

  rpcc_seq #(
    .RELAYS (RELAYS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_rel   (s_tdata[1:0]),
    .in_ready (s_tready),
    .busy     (busy),
    .out_free (!m_tvalid || m_tready),
    .ctrl     (ctrl)
  );

  rpcc_unit #(
    .PULSE_TICKS       (PULSE_TICKS),
    .COUNT_EVERY_PRESS (COUNT_EVERY_PRESS)
  ) u_unit (
    .mode     (ctrl.mode),
    .cur      (st[ridx]),
    .limit    (limit[ridx]),
    .cycle_ms (cycle_ms[ridx]),
    .cycle_nz (cycle_sec[ridx] != '0),
    .nxt      (nxt),
    .refused  (unit_refused),
    .flags    (flags)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RELAYS; i++) begin
        cycle_sec[i] <= '0;
        cycle_ms[i]  <= '0;
        limit[i]     <= '0;
      end
    end else if (cfg_wr && cfg_ok) begin
      if (creg < rpcc_pkg::REG_LIMIT_R0) begin
        cycle_sec[cidx] <= pwdata[rpcc_pkg::CYCLE_W-1:0];
        cycle_ms[cidx]  <= rpcc_pkg::AUTO_W'(pwdata[rpcc_pkg::CYCLE_W-1:0]) *
                           rpcc_pkg::AUTO_W'(rpcc_pkg::MS_PER_SEC);
      end else begin
        limit[cidx] <= pwdata[rpcc_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    if (cfg_ok) begin
      if (creg < rpcc_pkg::REG_LIMIT_R0) prdata = 32'(cycle_sec[cidx]);
      else                               prdata = 32'(limit[cidx]);
    end
  end

  // Relay state: write back the unit, restart the timer on a config write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RELAYS; i++) st[i] <= '0;
    end else if (cfg_wr && cfg_ok) begin
      st[cidx].autoel <= '0;
    end else if (writes_back) begin
      st[ridx] <= nxt;
    end
  end

  // Gather the report pass
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      drive_acc   <= '0;
      full_acc    <= '0;
      auto_acc    <= '0;
      recent_acc  <= '0;
      count_acc   <= '0;
      refused_acc <= 1'b0;
    end else begin
      if (ctrl.mode == rpcc_pkg::M_PRESS) refused_acc <= unit_refused;
      if (ctrl.mode == rpcc_pkg::M_RPT) begin
        drive_acc[ctrl.idx]  <= flags.drive;
        full_acc[ctrl.idx]   <= flags.full;
        auto_acc[ctrl.idx]   <= flags.autof;
        recent_acc[ctrl.idx] <= flags.recent;
        if (ctrl.rel_ok && (ctrl.idx == ctrl.rel)) count_acc <= st[ridx].cyc;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      relay_drive  <= drive_acc;
      cycle_count  <= count_acc;
      full_flags   <= full_acc;
      auto_flags   <= auto_acc;
      recent_flags <= recent_acc;
      refused      <= refused_acc;
    end
  end

  assign m_tdata = {7'b0, refused, recent_flags, auto_flags, full_flags,
                    cycle_count, relay_drive};

  // The input is closed while the unit works on an item
  a_closed_while_busy: assert property (@(posedge clk) disable iff (rst)
    (ctrl.mode != rpcc_pkg::M_NONE) |-> !s_tready)
    else $error("input ready while an item is at work");

  // A coil only starts on a press or an auto scan
  a_drive_source: assert property (@(posedge clk) disable iff (rst)
    (|(active_vec & ~$past(active_vec))) |->
      ($past(ctrl.mode) == rpcc_pkg::M_SCAN || $past(ctrl.mode) == rpcc_pkg::M_PRESS))
    else $error("coil driven outside a press");

  // A result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  // A refused press never drives its coil
  a_refused_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.mode == rpcc_pkg::M_PRESS && unit_refused) |=> $stable(active_vec))
    else $error("refused press changed the drive");

endmodule

`default_nettype wire
